// ===== rtl/core/rmst_pkg.sv =====
`timescale 1ns / 1ps

package rmst_pkg;

  localparam int unsigned POS_W      = 11;
  localparam int unsigned VALUE_W    = 16;
  localparam int unsigned LEAVES_DEF = 1024;

  typedef logic [POS_W-1:0]   pos_t;
  typedef logic [VALUE_W-1:0] val_t;

  localparam pos_t SIZE_RESET = pos_t'(1024);

  typedef enum logic {
    OP_UPDATE = 1'b0,
    OP_QUERY  = 1'b1
  } op_e;

  typedef struct packed {
    op_e  op;
    pos_t index;
    val_t value;
    pos_t left;
    pos_t right;
  } item_t;

  typedef struct packed {
    val_t max_value;
  } result_t;

  // node memory port enables
  typedef struct packed {
    logic rd0_en;
    logic rd1_en;
    logic wr_en;
  } mem_ctl_t;

  function automatic val_t vmax(val_t a, val_t b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/core/rmst_chan_if.sv =====
`timescale 1ns / 1ps

interface rmst_chan_if #(
  parameter type T = logic
) ();
  logic valid;
  logic ready;
  T     payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// ===== rtl/core/rmst_node_mem.sv =====
`timescale 1ns / 1ps

module rmst_node_mem
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic                             clk_i,
  input  mem_ctl_t                         ctl_i,
  input  logic [$clog2(2*LEAVES)-1:0]      wr_addr_i,
  input  val_t                             wr_data_i,
  input  logic [$clog2(2*LEAVES)-1:0]      rd0_addr_i,
  input  logic [$clog2(2*LEAVES)-1:0]      rd1_addr_i,
  output val_t                             rd0_data_o,
  output val_t                             rd1_data_o
);

  localparam int unsigned NODES = 2 * LEAVES;

  val_t mem_q [NODES];
  val_t rd0_q;
  val_t rd1_q;

  always_ff @(posedge clk_i) begin
    if (ctl_i.wr_en) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.rd0_en) begin
      rd0_q <= mem_q[rd0_addr_i];
    end
    if (ctl_i.rd1_en) begin
      rd1_q <= mem_q[rd1_addr_i];
    end
  end

  assign rd0_data_o = rd0_q;
  assign rd1_data_o = rd1_q;

endmodule

// ===== rtl/core/rmst_walk.sv =====
`timescale 1ns / 1ps

module rmst_walk
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  pos_t                         size_i,
  rmst_chan_if.sink                    item_i,
  rmst_chan_if.source                  result_o,
  output mem_ctl_t                     mem_ctl_o,
  output logic [$clog2(2*LEAVES)-1:0]  wr_addr_o,
  output val_t                         wr_data_o,
  output logic [$clog2(2*LEAVES)-1:0]  rd0_addr_o,
  output logic [$clog2(2*LEAVES)-1:0]  rd1_addr_o,
  input  val_t                         rd0_data_i,
  input  val_t                         rd1_data_i
);

  localparam int unsigned NODES = 2 * LEAVES;
  localparam int unsigned AW    = $clog2(NODES);
  localparam int unsigned NW    = AW + 1;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UP_LEAF,
    ST_UP_CLIMB,
    ST_Q_WALK,
    ST_Q_OUT
  } state_e;

  state_e        state_q;
  logic [AW-1:0] clr_q;
  logic [AW-1:0] node_q;
  logic [NW-1:0] lo_q;
  logic [NW-1:0] hi_q;
  val_t          val_q;
  val_t          cur_q;
  val_t          best_q;
  logic          hit0_q;
  logic          hit1_q;
  logic          out_valid_q;
  val_t          out_max_q;

  item_t         item;
  logic          accept;
  logic          up_ok;
  logic [NW-1:0] leaf_n;
  pos_t          q_lo;
  pos_t          q_hi;
  logic          q_hit;
  logic [NW-1:0] lo_n;
  logic [NW-1:0] hi_n;
  logic          walk_go;
  logic [AW-1:0] parent;
  logic          at_root;
  val_t          merged;
  val_t          climb;
  val_t          rd_sel;
  val_t          acc;
  logic          out_load;

  assign item   = item_i.payload;
  assign accept = item_i.valid && item_i.ready;
  assign item_i.ready = (state_q == ST_IDLE);

  assign up_ok  = (item.index != '0) && (item.index <= size_i);
  assign leaf_n = NW'(32'(LEAVES) + 32'(item.index) - 32'd1);

  // clamp bounds to 1..size
  assign q_lo  = (item.left == '0) ? pos_t'(1) : item.left;
  assign q_hi  = (item.right > size_i) ? size_i : item.right;
  assign q_hit = (q_lo <= q_hi);
  assign lo_n  = NW'(32'(LEAVES) + 32'(q_lo) - 32'd1);
  assign hi_n  = NW'(32'(LEAVES) + 32'(q_hi));

  assign walk_go = (lo_q < hi_q);
  assign parent  = node_q >> 1;
  assign at_root = (parent == AW'(1));
  assign merged  = vmax(rd0_data_i, val_q);
  assign climb   = vmax(cur_q, rd0_data_i);

  // fold in node reads issued in the previous cycle
  assign rd_sel = vmax(hit0_q ? rd0_data_i : '0, hit1_q ? rd1_data_i : '0);
  assign acc    = vmax(best_q, rd_sel);

  // output register takes a new result when empty or being drained this cycle
  assign out_load = (state_q == ST_Q_OUT) && (!out_valid_q || result_o.ready);

  always_comb begin
    mem_ctl_o  = '0;
    wr_addr_o  = node_q;
    wr_data_o  = merged;
    rd0_addr_o = node_q ^ AW'(1);
    rd1_addr_o = AW'(hi_q - NW'(1));
    unique case (state_q)
      ST_CLEAR: begin
        mem_ctl_o.wr_en = 1'b1;
        wr_addr_o       = clr_q;
        wr_data_o       = '0;
      end
      ST_IDLE: begin
        rd0_addr_o = leaf_n[AW-1:0];
        if (accept && item.op == OP_UPDATE && up_ok) begin
          mem_ctl_o.rd0_en = 1'b1;
        end
      end
      ST_UP_LEAF: begin
        mem_ctl_o.wr_en  = 1'b1;
        mem_ctl_o.rd0_en = 1'b1;
      end
      ST_UP_CLIMB: begin
        mem_ctl_o.wr_en  = 1'b1;
        wr_addr_o        = parent;
        wr_data_o        = climb;
        rd0_addr_o       = parent ^ AW'(1);
        mem_ctl_o.rd0_en = !at_root;
      end
      ST_Q_WALK: begin
        rd0_addr_o       = lo_q[AW-1:0];
        mem_ctl_o.rd0_en = walk_go && lo_q[0];
        mem_ctl_o.rd1_en = walk_go && hi_q[0];
      end
      ST_Q_OUT: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_q       <= '0;
      node_q      <= '0;
      lo_q        <= '0;
      hi_q        <= '0;
      val_q       <= '0;
      cur_q       <= '0;
      best_q      <= '0;
      hit0_q      <= 1'b0;
      hit1_q      <= 1'b0;
      out_valid_q <= 1'b0;
      out_max_q   <= '0;
    end else begin
      if (out_load) begin
        out_valid_q <= 1'b1;
        out_max_q   <= best_q;
      end else if (result_o.valid && result_o.ready) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_CLEAR: begin
          clr_q <= clr_q + AW'(1);
          if (clr_q == AW'(NODES - 1)) begin
            state_q <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            if (item.op == OP_UPDATE) begin
              if (up_ok) begin
                node_q  <= leaf_n[AW-1:0];
                val_q   <= item.value;
                state_q <= ST_UP_LEAF;
              end
            end else begin
              best_q <= '0;
              hit0_q <= 1'b0;
              hit1_q <= 1'b0;
              lo_q   <= lo_n;
              hi_q   <= hi_n;
              state_q <= q_hit ? ST_Q_WALK : ST_Q_OUT;
            end
          end
        end
        ST_UP_LEAF: begin
          cur_q   <= merged;
          state_q <= ST_UP_CLIMB;
        end
        ST_UP_CLIMB: begin
          node_q <= parent;
          cur_q  <= climb;
          if (at_root) begin
            state_q <= ST_IDLE;
          end
        end
        ST_Q_WALK: begin
          best_q <= acc;
          hit0_q <= walk_go && lo_q[0];
          hit1_q <= walk_go && hi_q[0];
          if (walk_go) begin
            lo_q <= (lo_q + NW'(lo_q[0])) >> 1;
            hi_q <= hi_q >> 1;
          end else begin
            state_q <= ST_Q_OUT;
          end
        end
        ST_Q_OUT: begin
          if (out_load) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign result_o.valid             = out_valid_q;
  assign result_o.payload.max_value = out_max_q;

endmodule

// ===== rtl/core/range_max_segment_tree.sv =====
`timescale 1ns / 1ps
// Update: an in-range index keeps the block busy after the transfer for the leaf-to-root
//   read/write walk over the node memory; an out-of-range index is dropped.
// Query: walks the node levels with up to two node reads per level; one item at a time,
//   result held in an output register.
// Reset: sizes to 1024, then clears all 2*LEAVES node memory entries one entry a cycle;
//   no item is taken until that pass ends, configuration is taken throughout.

module range_max_segment_tree
  import rmst_pkg::*;
#(
  parameter int unsigned LEAVES = LEAVES_DEF
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  rmst_chan_if.sink    cfg_i,
  rmst_chan_if.sink    item_i,
  rmst_chan_if.source  result_o
);

  localparam int unsigned AW = $clog2(2 * LEAVES);

  pos_t          size_q;
  pos_t          size_eff;
  mem_ctl_t      mem_ctl;
  logic [AW-1:0] wr_addr;
  val_t          wr_data;
  logic [AW-1:0] rd0_addr;
  logic [AW-1:0] rd1_addr;
  val_t          rd0_data;
  val_t          rd1_data;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_q <= SIZE_RESET;
    end else if (cfg_i.valid && cfg_i.ready) begin
      size_q <= cfg_i.payload;
    end
  end

  // a size above capacity acts as full capacity
  assign size_eff = (32'(size_q) > 32'(LEAVES)) ? pos_t'(LEAVES) : size_q;

  rmst_walk #(
    .LEAVES (LEAVES)
  ) u_walk (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .size_i     (size_eff),
    .item_i     (item_i),
    .result_o   (result_o),
    .mem_ctl_o  (mem_ctl),
    .wr_addr_o  (wr_addr),
    .wr_data_o  (wr_data),
    .rd0_addr_o (rd0_addr),
    .rd1_addr_o (rd1_addr),
    .rd0_data_i (rd0_data),
    .rd1_data_i (rd1_data)
  );

  rmst_node_mem #(
    .LEAVES (LEAVES)
  ) u_mem (
    .clk_i      (clk_i),
    .ctl_i      (mem_ctl),
    .wr_addr_i  (wr_addr),
    .wr_data_i  (wr_data),
    .rd0_addr_i (rd0_addr),
    .rd1_addr_i (rd1_addr),
    .rd0_data_o (rd0_data),
    .rd1_data_o (rd1_data)
  );

endmodule

// ===== sim/range_max_segment_tree_tb.sv =====
`timescale 1ns / 1ps

module range_max_segment_tree_tb;
  import rmst_pkg::*;

  localparam int unsigned TREE_LEAVES = LEAVES_DEF;
  localparam int unsigned RAND_ITEMS  = 1000;
  // a quiet stretch this long means the block has hung
  localparam int unsigned STALL_LIMIT = 10000;
  // an update walk gives no result, so wait it out before a size write
  localparam int unsigned SETTLE      = 24;
  localparam int unsigned TAIL        = 32;

  typedef struct packed {
    op_e  op;
    pos_t index;
    val_t value;
    pos_t left;
    pos_t right;
    logic fixed;
    val_t want;
  } probe_t;

  typedef struct packed {
    logic fixed;
    val_t want;
  } hint_t;

  localparam probe_t PROBES [25] = '{
    '{OP_QUERY,  11'd0,    16'h0000, 11'd1,    11'd1024, 1'b1, 16'h0000},
    '{OP_QUERY,  11'd2047, 16'hffff, 11'd0,    11'd2047, 1'b1, 16'h0000},
    '{OP_UPDATE, 11'd0,    16'hffff, 11'd0,    11'd2047, 1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd0,    11'd2047, 1'b1, 16'h0000},
    '{OP_UPDATE, 11'd1,    16'hffff, 11'd1,    11'd1,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd1,    11'd1,    1'b1, 16'hffff},
    '{OP_UPDATE, 11'd1024, 16'h0001, 11'd2047, 11'd0,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd1024, 11'd1024, 1'b1, 16'h0001},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd2,    11'd1023, 1'b1, 16'h0000},
    '{OP_UPDATE, 11'd1025, 16'h0309, 11'd0,    11'd0,    1'b0, 16'h0000},
    '{OP_UPDATE, 11'd2047, 16'h5555, 11'd0,    11'd0,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd0,    11'd2047, 1'b1, 16'hffff},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd2,    11'd2047, 1'b1, 16'h0001},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd5,    11'd3,    1'b1, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd2047, 11'd2047, 1'b1, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd0,    11'd0,    1'b1, 16'h0000},
    '{OP_UPDATE, 11'd512,  16'h8000, 11'd7,    11'd9,    1'b0, 16'h0000},
    '{OP_UPDATE, 11'd512,  16'h1234, 11'd0,    11'd0,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd500,  11'd600,  1'b1, 16'h8000},
    '{OP_UPDATE, 11'd513,  16'haaaa, 11'd0,    11'd0,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd1,    16'h0001, 11'd512,  11'd513,  1'b0, 16'h0000},
    '{OP_UPDATE, 11'd700,  16'h5555, 11'd0,    11'd0,    1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd1,    11'd1023, 1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd513,  11'd700,  1'b0, 16'h0000},
    '{OP_QUERY,  11'd0,    16'h0000, 11'd1023, 11'd1024, 1'b0, 16'h0000}
  };

  logic clk_i;
  logic rst_ni;

  rmst_chan_if #(.T(pos_t))    cfg_if ();
  rmst_chan_if #(.T(item_t))   item_if ();
  rmst_chan_if #(.T(result_t)) result_if ();

  range_max_segment_tree #(
    .LEAVES(TREE_LEAVES)
  ) DUT (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cfg_i   (cfg_if.sink),
    .item_i  (item_if.sink),
    .result_o(result_if.source)
  );

  initial clk_i = 1'b0;
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // mirror of the tree and of the size register
  val_t        node_mirror [2*TREE_LEAVES];
  pos_t        mirror_size;
  val_t        max_due_q [$];
  hint_t       hint_q [$];
  int unsigned mismatches;
  int unsigned quiet_cycles;

  function automatic int unsigned live_size(pos_t sz);
    return (sz > TREE_LEAVES) ? TREE_LEAVES : int'(sz);
  endfunction

  function automatic void mirror_raise(int unsigned pos, val_t v);
    int unsigned k;
    k = TREE_LEAVES + pos - 1;
    if (v > node_mirror[k]) node_mirror[k] = v;
    while (k > 1) begin
      k = k >> 1;
      node_mirror[k] = (node_mirror[2*k] > node_mirror[2*k+1]) ?
                       node_mirror[2*k] : node_mirror[2*k+1];
    end
  endfunction

  function automatic val_t mirror_span_max(int unsigned lo_pos, int unsigned hi_pos);
    int unsigned lo;
    int unsigned hi;
    val_t        best;
    lo   = TREE_LEAVES + lo_pos - 1;
    hi   = TREE_LEAVES + hi_pos;
    best = '0;
    while (lo < hi) begin
      if (lo[0]) begin
        if (node_mirror[lo] > best) best = node_mirror[lo];
        lo++;
      end
      if (hi[0]) begin
        hi--;
        if (node_mirror[hi] > best) best = node_mirror[hi];
      end
      lo = lo >> 1;
      hi = hi >> 1;
    end
    return best;
  endfunction

  // returns 1 when the item produces a result
  function automatic bit mirror_apply(item_t it, output val_t res);
    int unsigned sz;
    int unsigned lo;
    int unsigned hi;
    sz  = live_size(mirror_size);
    res = '0;
    if (it.op == OP_UPDATE) begin
      if (it.index >= 1 && it.index <= sz) mirror_raise(it.index, it.value);
      return 1'b0;
    end
    lo = (it.left < 1) ? 1 : int'(it.left);
    hi = (it.right > sz) ? sz : int'(it.right);
    if (lo <= hi) res = mirror_span_max(lo, hi);
    return 1'b1;
  endfunction

  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic item_t random_item(int unsigned sz);
    item_t       it;
    bit          noise;
    int unsigned lo;
    int unsigned top;
    noise    = (sz == 0) || ($urandom_range(0, 9) == 0);
    it.op    = $urandom_range(0, 1) ? OP_QUERY : OP_UPDATE;
    // fields the operation ignores carry junk
    it.index = pos_t'($urandom_range(0, 2047));
    it.value = val_t'($urandom_range(0, 65535) >> $urandom_range(0, 15));
    it.left  = pos_t'($urandom_range(0, 2047));
    it.right = pos_t'($urandom_range(0, 2047));
    if (!noise) begin
      if (it.op == OP_UPDATE) begin
        it.index = pos_t'($urandom_range(1, sz));
      end else begin
        lo  = $urandom_range(1, sz);
        top = ($urandom_range(0, 3) == 0 || lo + 31 > sz) ? sz : lo + 31;
        it.left  = pos_t'(lo);
        it.right = pos_t'($urandom_range(lo, top));
      end
    end
    return it;
  endfunction

  task automatic send_item(item_t it, hint_t h, int unsigned gap);
    hint_q.push_back(h);
    item_if.valid   <= 1'b1;
    item_if.payload <= it;
    @(posedge clk_i);
    while (!item_if.ready) @(posedge clk_i);
    if (gap > 0) begin
      item_if.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (max_due_q.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_size(pos_t sz);
    cfg_if.valid   <= 1'b1;
    cfg_if.payload <= sz;
    @(posedge clk_i);
    while (!cfg_if.ready) @(posedge clk_i);
    cfg_if.valid <= 1'b0;
    @(posedge clk_i);
  endtask

  // stimulus
  initial begin
    pos_t        sizes [6];
    pos_t        cur_size;
    item_t       it;
    hint_t       h;
    int unsigned live;
    int unsigned phase;
    int unsigned n_items;
    int unsigned gap;
    int unsigned sz;
    bit          steady;
    bit          pause;
    sizes = '{11'd1, 11'd2047, 11'd0, 11'd2, 11'd1025, 11'd1024};
    foreach (node_mirror[k]) node_mirror[k] = '0;
    mirror_size     = SIZE_RESET;
    mismatches      = 0;
    rst_ni          = 1'b0;
    cfg_if.valid    <= 1'b0;
    cfg_if.payload  <= '0;
    item_if.valid   <= 1'b0;
    item_if.payload <= '0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    cur_size = pos_t'(TREE_LEAVES);
    write_size(cur_size);
    foreach (PROBES[i]) begin
      it.op    = PROBES[i].op;
      it.index = PROBES[i].index;
      it.value = PROBES[i].value;
      it.left  = PROBES[i].left;
      it.right = PROBES[i].right;
      h.fixed  = PROBES[i].fixed;
      h.want   = PROBES[i].want;
      gap = idle_len();
      send_item(it, h, (i == $size(PROBES) - 1 && gap == 0) ? 1 : gap);
    end

    live  = 0;
    phase = 0;
    while (live < RAND_ITEMS) begin
      // size writes only once the block has gone quiet
      drain();
      repeat (SETTLE) @(posedge clk_i);
      if (phase < $size(sizes))
        cur_size = sizes[phase];
      else if ($urandom_range(0, 4) == 0)
        cur_size = sizes[$urandom_range(0, $size(sizes) - 1)];
      else
        cur_size = pos_t'($urandom_range(1, TREE_LEAVES));
      write_size(cur_size);
      sz      = live_size(cur_size);
      steady  = ($urandom_range(0, 3) == 0);
      n_items = $urandom_range(40, 120);
      h.fixed = 1'b0;
      h.want  = '0;
      for (int unsigned n = 0; n < n_items; n++) begin
        it    = random_item(sz);
        pause = ($urandom_range(0, 63) == 0) || (n == n_items - 1);
        gap   = steady ? 0 : idle_len();
        if (pause && gap == 0) gap = 1;
        send_item(it, h, gap);
        if (it.op == OP_QUERY || (it.index >= 1 && it.index <= sz)) live++;
        if (pause) drain();
      end
      phase++;
    end

    drain();
    repeat (TAIL) @(posedge clk_i);
    if (mismatches == 0 && max_due_q.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  // result side back-pressure
  initial begin
    bit          rx_steady;
    int unsigned stall;
    rx_steady = 1'b0;
    forever begin
      if ($urandom_range(0, 31) == 0) rx_steady = !rx_steady;
      stall = rx_steady ? 0 : idle_len();
      if (stall > 0) begin
        result_if.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      result_if.ready <= 1'b1;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  end

  always @(posedge clk_i) begin
    if (cfg_if.valid && cfg_if.ready) mirror_size = cfg_if.payload;
  end

  always @(posedge clk_i) begin
    val_t  res;
    hint_t h;
    if (item_if.valid && item_if.ready) begin
      h = hint_q.pop_front();
      if (mirror_apply(item_if.payload, res)) max_due_q.push_back(h.fixed ? h.want : res);
    end
  end

  always @(posedge clk_i) begin
    val_t want;
    if (result_if.valid && result_if.ready) begin
      if (max_due_q.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected result transfer, max_value %h", $time,
                   result_if.payload.max_value);
        mismatches++;
      end else begin
        want = max_due_q.pop_front();
        if (result_if.payload.max_value !== want) begin
          if (mismatches < 10)
            $display("%0t: max_value mismatch, expected %h got %h", $time, want,
                     result_if.payload.max_value);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (cfg_if.valid && cfg_if.ready) || (item_if.valid && item_if.ready) ||
        (result_if.valid && result_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

endmodule
